>>> rtl/ppp_pkg.sv
// ---------------------------------------------------------------------------
// ppp_pkg
// Shared widths and control types of the perspective point projector.
// ---------------------------------------------------------------------------
package ppp_pkg;

	// Camera-space coordinate: difference of two 32-bit values.
	localparam int CAM_W = 33;
	// Depth divisor, minus camera-space z, always below 2^32 when used.
	localparam int DZ_W = 32;
	// Scale register width.
	localparam int SCALE_W = 24;
	// Numerator magnitude: 33-bit magnitude times 24-bit scale.
	localparam int NUM_W = CAM_W + SCALE_W;
	// Screen size register width.
	localparam int SIZE_W = 13;
	localparam int PIX_W = 16;
	localparam int PIX_MAX = 32767;
	localparam int PIX_MIN = -32768;

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_CAM_X = 3'd0;
	localparam logic [2:0] REG_CAM_Y = 3'd1;
	localparam logic [2:0] REG_CAM_Z = 3'd2;
	localparam logic [2:0] REG_HSCALE = 3'd3;
	localparam logic [2:0] REG_VSCALE = 3'd4;
	localparam logic [2:0] REG_WIDTH = 3'd5;
	localparam logic [2:0] REG_HEIGHT = 3'd6;

	// Control word that travels with every point down the pipeline.
	typedef struct packed {
		logic valid;
		logic behind;
		logic neg_x;
		logic neg_y;
		logic ovf_x;
		logic ovf_y;
	} ppp_ctl_t;

endpackage

>>> rtl/ppp_div_step.sv
// ---------------------------------------------------------------------------
// ppp_div_step
// One registered restoring division step: one quotient bit per stage.
// ---------------------------------------------------------------------------
module ppp_div_step #(
	parameter int QB = 34
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic [ppp_pkg::DZ_W-1:0] dz,
	input  logic [ppp_pkg::DZ_W-1:0] rem_in,
	input  logic [QB-1:0]           lo_in,
	input  logic [QB-1:0]           quo_in,
	output logic [ppp_pkg::DZ_W-1:0] rem_next,
	output logic [QB-1:0]           lo_next,
	output logic [QB-1:0]           quo_next
);
	import ppp_pkg::*;

	logic [DZ_W:0]   trial;
	logic [DZ_W:0]   diff;
	logic            ge;
	logic [DZ_W-1:0] rem_new;

	always_comb begin
		trial = {rem_in, lo_in[QB-1]};
		diff = trial - {1'b0, dz};
		ge = (trial >= {1'b0, dz});
		// The remainder stays below the divisor, so it fits in DZ_W bits.
		rem_new = ge ? diff[DZ_W-1:0] : trial[DZ_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_next <= rem_new;
			lo_next <= {lo_in[QB-2:0], 1'b0};
			quo_next <= {quo_in[QB-2:0], ge};
		end
	end

endmodule

>>> rtl/ppp_divider.sv
// ---------------------------------------------------------------------------
// ppp_divider
// Pipelined unsigned divider for both plane axes sharing one depth divisor.
// ---------------------------------------------------------------------------
module ppp_divider #(
	parameter int QB = 34
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  ppp_pkg::ppp_ctl_t        ctl,
	input  logic [ppp_pkg::NUM_W-1:0] num_x,
	input  logic [ppp_pkg::NUM_W-1:0] num_y,
	input  logic [ppp_pkg::DZ_W-1:0]  dz,
	output ppp_pkg::ppp_ctl_t        ctl_res,
	output logic [QB-1:0]            quo_x,
	output logic [QB-1:0]            quo_y
);
	import ppp_pkg::*;

	ppp_ctl_t        ctl_s [QB+1];
	logic [DZ_W-1:0] dz_s [QB+1];
	logic [DZ_W-1:0] rem_x_s [QB+1];
	logic [DZ_W-1:0] rem_y_s [QB+1];
	logic [QB-1:0]   lo_x_s [QB+1];
	logic [QB-1:0]   lo_y_s [QB+1];
	logic [QB-1:0]   quo_x_s [QB+1];
	logic [QB-1:0]   quo_y_s [QB+1];

	logic [NUM_W-1:0] hi_x;
	logic [NUM_W-1:0] hi_y;
	logic             ovf_x;
	logic             ovf_y;

	// A quotient of 2^QB or more is far past the plane clamp; it is flagged
	// and the remaining steps run on zero.
	always_comb begin
		hi_x = num_x >> QB;
		hi_y = num_y >> QB;
		ovf_x = (hi_x >= NUM_W'(dz));
		ovf_y = (hi_y >= NUM_W'(dz));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else if (en) begin
			ctl_s[0] <= '{valid: ctl.valid, behind: ctl.behind, neg_x: ctl.neg_x,
				neg_y: ctl.neg_y, ovf_x: ovf_x, ovf_y: ovf_y};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dz_s[0] <= dz;
			rem_x_s[0] <= ovf_x ? '0 : hi_x[DZ_W-1:0];
			rem_y_s[0] <= ovf_y ? '0 : hi_y[DZ_W-1:0];
			lo_x_s[0] <= num_x[QB-1:0];
			lo_y_s[0] <= num_y[QB-1:0];
			quo_x_s[0] <= '0;
			quo_y_s[0] <= '0;
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_step
		ppp_div_step #(.QB(QB)) u_step_x (
			.clk(clk), .en(en), .dz(dz_s[k]),
			.rem_in(rem_x_s[k]), .lo_in(lo_x_s[k]), .quo_in(quo_x_s[k]),
			.rem_next(rem_x_s[k+1]), .lo_next(lo_x_s[k+1]), .quo_next(quo_x_s[k+1])
		);
		ppp_div_step #(.QB(QB)) u_step_y (
			.clk(clk), .en(en), .dz(dz_s[k]),
			.rem_in(rem_y_s[k]), .lo_in(lo_y_s[k]), .quo_in(quo_y_s[k]),
			.rem_next(rem_y_s[k+1]), .lo_next(lo_y_s[k+1]), .quo_next(quo_y_s[k+1])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k+1] <= '0;
			end else if (en) begin
				ctl_s[k+1] <= ctl_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dz_s[k+1] <= dz_s[k];
			end
		end
	end

	// The last remainders and divisor copy feed nothing further.
	assign ctl_res = ctl_s[QB];
	assign quo_x = quo_x_s[QB];
	assign quo_y = quo_y_s[QB];

endmodule

>>> rtl/ppp_pixel.sv
// ---------------------------------------------------------------------------
// ppp_pixel
// Maps plane coordinates to saturated pixel coordinates in two stages.
// ---------------------------------------------------------------------------
module ppp_pixel #(
	parameter int FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  ppp_pkg::ppp_ctl_t                ctl,
	input  logic [FRAC_BITS+17:0]            quo_x,
	input  logic [FRAC_BITS+17:0]            quo_y,
	input  logic [ppp_pkg::SIZE_W-1:0]        view_w,
	input  logic [ppp_pkg::SIZE_W-1:0]        view_h,
	output logic                             out_valid,
	output logic signed [ppp_pkg::PIX_W-1:0] pixel_x,
	output logic signed [ppp_pkg::PIX_W-1:0] pixel_y,
	output logic                             behind_camera,
	output logic                             clipped
);
	import ppp_pkg::*;

	localparam int QB = FRAC_BITS + 18;
	localparam int PW = FRAC_BITS + 20;
	localparam int PRW = PW + SIZE_W + 1;
	localparam logic [QB-1:0] LIM = QB'(1) << (FRAC_BITS + 17);
	localparam logic signed [PW-1:0] ONE = PW'(1) << FRAC_BITS;
	localparam logic signed [PRW-1:0] BIAS = (PRW'(1) << (FRAC_BITS + 1)) - PRW'(1);
	localparam logic signed [PRW-1:0] PMAX = PRW'(PIX_MAX);
	localparam logic signed [PRW-1:0] PMIN = PRW'(PIX_MIN);

	// Clamped, signed plane value plus one, as a signed numerator.
	function automatic logic signed [PW-1:0] plane_num(input logic [QB-1:0] q,
		input logic ovf, input logic neg);
		logic [QB-1:0]          mag;
		logic signed [PW-1:0]   val;
		mag = (ovf || (q > LIM)) ? LIM : q;
		val = $signed(PW'(mag));
		return (neg ? -val : val) + ONE;
	endfunction

	// Truncating divide by 2^(FRAC_BITS+1), then 16-bit saturation.
	function automatic logic [PIX_W:0] to_pix(input logic signed [PRW-1:0] p);
		logic signed [PRW-1:0] r;
		r = p;
		if (p[PRW-1]) begin
			r = p + BIAS;
		end
		r = r >>> (FRAC_BITS + 1);
		if (r > PMAX) begin
			return {1'b1, PMAX[PIX_W-1:0]};
		end else if (r < PMIN) begin
			return {1'b1, PMIN[PIX_W-1:0]};
		end
		return {1'b0, r[PIX_W-1:0]};
	endfunction

	ppp_ctl_t              ctl_s1;
	logic signed [PRW-1:0] prod_x_s1;
	logic signed [PRW-1:0] prod_y_s1;
	logic [PIX_W:0]        res_x;
	logic [PIX_W:0]        res_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl;
		end
	end

	// The y axis is flipped: one minus the plane value.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_x_s1 <= PRW'(plane_num(quo_x, ctl.ovf_x, ctl.neg_x))
				* $signed({1'b0, view_w});
			prod_y_s1 <= PRW'(plane_num(quo_y, ctl.ovf_y, !ctl.neg_y))
				* $signed({1'b0, view_h});
		end
	end

	always_comb begin
		res_x = to_pix(prod_x_s1);
		res_y = to_pix(prod_y_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= ctl_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			behind_camera <= ctl_s1.behind;
			if (ctl_s1.behind) begin
				pixel_x <= '0;
				pixel_y <= '0;
				clipped <= 1'b0;
			end else begin
				pixel_x <= $signed(res_x[PIX_W-1:0]);
				pixel_y <= $signed(res_y[PIX_W-1:0]);
				clipped <= res_x[PIX_W] | res_y[PIX_W];
			end
		end
	end

endmodule

>>> rtl/perspective_point_projection.sv
// ---------------------------------------------------------------------------
// perspective_point_projection
// Projects world-space points onto the screen with a camera and scales.
// ---------------------------------------------------------------------------
// The block takes one world point in signed Q16.16 per transfer and returns
// one screen coordinate pair per point, in order. It accepts a new point in
// every cycle unless in_stall is raised. The divider resolves one quotient
// bit per stage for the x and y lanes side by side.
// The pipeline moves as a whole:
// when a finished result waits at the output under stall, every stage holds
// and in_stall is raised, so nothing is lost or repeated. Points at or behind
// the camera plane come out with behind_camera set and zero coordinates.
// Coordinates beyond the 16-bit range saturate and raise clipped. The
// configuration port always takes writes; registers should be written only
// while no point is in flight.
// ---------------------------------------------------------------------------
module perspective_point_projection #(
	parameter int FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [31:0]               world_x,
	input  logic signed [31:0]               world_y,
	input  logic signed [31:0]               world_z,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [ppp_pkg::PIX_W-1:0] pixel_x,
	output logic signed [ppp_pkg::PIX_W-1:0] pixel_y,
	output logic                             behind_camera,
	output logic                             clipped,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [2:0]                       cfg_index,
	input  logic [31:0]                      cfg_data
);
	import ppp_pkg::*;

	localparam int QB = FRAC_BITS + 18;

	logic signed [31:0] cam_x_q;
	logic signed [31:0] cam_y_q;
	logic signed [31:0] cam_z_q;
	logic [SCALE_W-1:0] hscale_q;
	logic [SCALE_W-1:0] vscale_q;
	logic [SIZE_W-1:0]  width_q;
	logic [SIZE_W-1:0]  height_q;

	// Every stage advances unless a finished result is held at the output.
	logic en;
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q <= '0;
			cam_y_q <= '0;
			cam_z_q <= '0;
			hscale_q <= SCALE_W'(85134);
			vscale_q <= SCALE_W'(113512);
			width_q <= SIZE_W'(640);
			height_q <= SIZE_W'(480);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CAM_X: cam_x_q <= cfg_data;
				REG_CAM_Y: cam_y_q <= cfg_data;
				REG_CAM_Z: cam_z_q <= cfg_data;
				REG_HSCALE: hscale_q <= cfg_data[SCALE_W-1:0];
				REG_VSCALE: vscale_q <= cfg_data[SCALE_W-1:0];
				REG_WIDTH: width_q <= cfg_data[SIZE_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage 1: camera-space coordinates, exact in 33 bits.
	logic                     valid_s1;
	logic signed [CAM_W-1:0]  cx_s1;
	logic signed [CAM_W-1:0]  cy_s1;
	logic signed [CAM_W-1:0]  cz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s1 <= CAM_W'(world_x) - CAM_W'(cam_x_q);
			cy_s1 <= CAM_W'(world_y) - CAM_W'(cam_y_q);
			cz_s1 <= CAM_W'(world_z) - CAM_W'(cam_z_q);
		end
	end

	// Stage 2: the divider works on magnitudes; the signs travel alongside.
	// The depth is positive whenever the point lies in front of the camera.
	logic [CAM_W-1:0] ax;
	logic [CAM_W-1:0] ay;
	logic [CAM_W-1:0] nz;
	ppp_ctl_t         ctl_s2;
	logic [NUM_W-1:0] nx_s2;
	logic [NUM_W-1:0] ny_s2;
	logic [DZ_W-1:0]  dz_s2;

	always_comb begin
		ax = cx_s1[CAM_W-1] ? CAM_W'(-cx_s1) : CAM_W'(cx_s1);
		ay = cy_s1[CAM_W-1] ? CAM_W'(-cy_s1) : CAM_W'(cy_s1);
		nz = CAM_W'(-cz_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2 <= '{valid: valid_s1, behind: !cz_s1[CAM_W-1],
				neg_x: cx_s1[CAM_W-1], neg_y: cy_s1[CAM_W-1],
				ovf_x: 1'b0, ovf_y: 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s2 <= NUM_W'(ax) * NUM_W'(hscale_q);
			ny_s2 <= NUM_W'(ay) * NUM_W'(vscale_q);
			// For a point behind the camera the divisor is don't-care;
			// force it nonzero so the divider stays well defined.
			dz_s2 <= cz_s1[CAM_W-1] ? nz[DZ_W-1:0] : DZ_W'(1);
		end
	end

	ppp_ctl_t      ctl_div;
	logic [QB-1:0] quo_x;
	logic [QB-1:0] quo_y;

	ppp_divider #(.QB(QB)) u_divider (
		.clk(clk), .arst_n(arst_n), .en(en), .ctl(ctl_s2),
		.num_x(nx_s2), .num_y(ny_s2), .dz(dz_s2),
		.ctl_res(ctl_div), .quo_x(quo_x), .quo_y(quo_y)
	);

	ppp_pixel #(.FRAC_BITS(FRAC_BITS)) u_pixel (
		.clk(clk), .arst_n(arst_n), .en(en), .ctl(ctl_div),
		.quo_x(quo_x), .quo_y(quo_y),
		.view_w(width_q), .view_h(height_q),
		.out_valid(out_valid), .pixel_x(pixel_x), .pixel_y(pixel_y),
		.behind_camera(behind_camera), .clipped(clipped)
	);

	// A point behind the camera carries no coordinates.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && behind_camera |-> pixel_x == 0 && pixel_y == 0 && !clipped)
		else $error("behind-camera result carries coordinates");

	// A clipped result sits at a limit of the 16-bit range.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clipped |-> pixel_x == 16'sh7fff || pixel_x == -16'sh8000 ||
			pixel_y == 16'sh7fff || pixel_y == -16'sh8000)
		else $error("clipped result not at a saturation limit");

	// The input side is held back only by a result waiting at the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held result");

endmodule

>>> tb/perspective_point_projection_test.sv
// ---------------------------------------------------------------------------
// Perspective point projection testbench
// Drives world points through the projector with random gaps and stalls,
// computes the expected screen coordinates and flags in an independent
// predictor, and compares every output transfer in order. Camera position,
// scales and screen size are changed between phases while the block is idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

class projection_scoreboard;
	typedef struct {
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic               behind;
		logic               clip;
	} screen_point_t;

	// Configuration mirror, held at widths that cannot overflow.
	longint cam_x, cam_y, cam_z;
	longint h_scale, v_scale, width, height;
	screen_point_t pending[$];
	int mismatches;

	function new();
		cam_x = 0;
		cam_y = 0;
		cam_z = 0;
		h_scale = 85134;
		v_scale = 113512;
		width = 640;
		height = 480;
		mismatches = 0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [31:0] data);
		case (idx)
			ppp_pkg::REG_CAM_X: begin
				cam_x = longint'($signed(data));
			end
			ppp_pkg::REG_CAM_Y: begin
				cam_y = longint'($signed(data));
			end
			ppp_pkg::REG_CAM_Z: begin
				cam_z = longint'($signed(data));
			end
			ppp_pkg::REG_HSCALE: begin
				h_scale = longint'(data[23:0]);
			end
			ppp_pkg::REG_VSCALE: begin
				v_scale = longint'(data[23:0]);
			end
			ppp_pkg::REG_WIDTH: begin
				width = longint'(data[12:0]);
			end
			ppp_pkg::REG_HEIGHT: begin
				height = longint'(data[12:0]);
			end
			default: begin
			end
		endcase
	endfunction

	// Maps a plane value offset by one onto pixels, with saturation.
	function longint scale_to_pixel(longint num, longint size, ref bit sat);
		longint r;
		r = (num * size) / (longint'(1) << 17);
		if (r > 32767) begin
			sat = 1;
			return 32767;
		end
		if (r < -32768) begin
			sat = 1;
			return -32768;
		end
		return r;
	endfunction

	function longint clamp_plane(longint p);
		longint lim;
		lim = longint'(1) << 33;
		if (p > lim) return lim;
		if (p < -lim) return -lim;
		return p;
	endfunction

	function void note_point(logic signed [31:0] wx, logic signed [31:0] wy,
			logic signed [31:0] wz);
		screen_point_t e;
		longint cx, cy, cz, dz, px, py;
		bit sat;
		cx = longint'(wx) - cam_x;
		cy = longint'(wy) - cam_y;
		cz = longint'(wz) - cam_z;
		sat = 0;
		e.px = 0;
		e.py = 0;
		e.behind = 1;
		e.clip = 0;
		if (cz < 0) begin
			dz = -cz;
			px = clamp_plane((cx * h_scale) / dz);
			py = clamp_plane((cy * v_scale) / dz);
			e.px = 16'(scale_to_pixel(px + 65536, width, sat));
			e.py = 16'(scale_to_pixel(65536 - py, height, sat));
			e.behind = 0;
			e.clip = sat;
		end
		pending.push_back(e);
	endfunction

	function void check_point(logic signed [15:0] px, logic signed [15:0] py,
			logic behind, logic clip);
		screen_point_t e;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result transfer: %0d %0d %b %b", px, py, behind, clip);
			return;
		end
		e = pending.pop_front();
		if (px !== e.px || py !== e.py || behind !== e.behind || clip !== e.clip) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result mismatch: expected x=%0d y=%0d behind=%b clipped=%b,"
					, e.px, e.py, e.behind, e.clip,
					" got x=%0d y=%0d behind=%b clipped=%b", px, py, behind, clip);
		end
	endfunction
endclass

module perspective_point_projection_test;
	import ppp_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 60;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [31:0] world_x = 0, world_y = 0, world_z = 0;
	logic out_valid;
	logic out_stall = 1;
	logic signed [PIX_W-1:0] pixel_x, pixel_y;
	logic behind_camera, clipped;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [2:0] cfg_index = 0;
	logic [31:0] cfg_data = 0;

	projection_scoreboard board;
	int idle_cycles;
	bit out_stall_random;

	perspective_point_projection uut (.*);

	always #6 clk = ~clk;

	// Every output transfer is checked at the rising edge where it happens.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_point(pixel_x, pixel_y, behind_camera, clipped);
	end

	// The watchdog counts cycles in which no transfer happens on any channel.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// The receiving side stalls for a random number of cycles before each
	// transfer; with random mode off it never stalls.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = out_stall_random ? $urandom_range(0, 19) : 0;
			if (gap > 0) begin
				out_stall <= 1;
				repeat (gap) @(negedge clk);
			end
			out_stall <= 0;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic write_config(logic [2:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	// One point transfer; gap is the number of idle cycles before it.
	task automatic send_point(logic [31:0] wx, logic [31:0] wy, logic [31:0] wz, int gap);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1;
		world_x <= wx;
		world_y <= wy;
		world_z <= wz;
		do @(posedge clk); while (in_stall);
		board.note_point(wx, wy, wz);
	endtask

	task automatic end_burst();
		@(negedge clk);
		in_valid <= 0;
	endtask

	// Waits for every expected result, then for the pipeline to settle.
	task automatic drain();
		end_burst();
		while (board.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// A point mostly in front of the camera near the view frustum so the
	// coordinates land on screen, sometimes anywhere in the field range.
	task automatic random_point(int gap);
		logic [31:0] wx, wy, wz;
		wx = $urandom;
		wy = $urandom;
		wz = $urandom;
		if ($urandom_range(0, 3) != 0) begin
			wz = board.cam_z - $urandom_range(1, 32'h00ff_ffff);
			wx = board.cam_x + $signed($urandom_range(0, 32'h01ff_ffff)) - 32'h00ff_ffff;
			wy = board.cam_y + $signed($urandom_range(0, 32'h01ff_ffff)) - 32'h00ff_ffff;
		end
		send_point(wx, wy, wz, gap);
	endtask

	task automatic random_config();
		write_config(REG_CAM_X, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h000f_ffff));
		write_config(REG_CAM_Y, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h000f_ffff));
		write_config(REG_CAM_Z, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h000f_ffff));
		write_config(REG_HSCALE, $urandom_range(0, 32'h0004_0000));
		write_config(REG_VSCALE, $urandom_range(0, 32'h0004_0000));
		write_config(REG_WIDTH, $urandom_range(1, 4096));
		write_config(REG_HEIGHT, $urandom_range(1, 4096));
	endtask

	initial begin
		board = new();
		out_stall_random = 0;
		idle_cycles = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed points at the reset configuration: center, edges of the
		// fields, the camera plane itself and points behind it.
		send_point(0, 0, 32'hffff_0000, 0);
		send_point(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 0);
		send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0);
		send_point(32'h0001_0000, 32'hffff_0000, 32'hfffe_0000, 0);
		send_point(0, 0, 0, 0);
		send_point(32'h1234_5678, 32'h8765_4321, 32'h7fff_ffff, 0);
		send_point(32'hffff_ffff, 32'hffff_ffff, 32'h0000_0001, 0);
		send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 0);
		drain();

		// Extreme configuration: camera at the field limits, maximum scales, a 4096
		// by 4096 screen, with points at the far ends of the camera-space range.
		write_config(REG_CAM_X, 32'h8000_0000);
		write_config(REG_CAM_Y, 32'h7fff_ffff);
		write_config(REG_CAM_Z, 32'h7fff_ffff);
		write_config(REG_HSCALE, 32'h00ff_ffff);
		write_config(REG_VSCALE, 32'h00ff_ffff);
		write_config(REG_WIDTH, 4096);
		write_config(REG_HEIGHT, 4096);
		// Out-of-range index; the block ignores it.
		write_config(3'd7, 32'hdead_beef);
		send_point(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 0);
		send_point(0, 0, 32'h7fff_fffe, 0);
		send_point(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 0);
		send_point(32'h0000_0001, 32'hffff_ffff, 32'h0000_0000, 0);
		drain();

		// Zero scales collapse to the center; a one by one pixel screen.
		write_config(REG_CAM_X, 0);
		write_config(REG_CAM_Y, 0);
		write_config(REG_CAM_Z, 0);
		write_config(REG_HSCALE, 0);
		write_config(REG_VSCALE, 0);
		write_config(REG_WIDTH, 1);
		write_config(REG_HEIGHT, 1);
		send_point(32'h7fff_ffff, 32'h8000_0000, 32'hffff_0000, 0);
		send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0);
		send_point(32'h0100_0000, 32'hff00_0000, 32'hffff_ffff, 0);
		drain();

		// Random phases, each with a fresh configuration, random gaps on both
		// sides and some bursts without any gaps at all.
		out_stall_random = 1;
		for (int phase = 0; phase < 16; phase++) begin
			bit no_gaps;
			random_config();
			no_gaps = (phase % 4 == 3);
			out_stall_random = !no_gaps;
			for (int n = 0; n < 50; n++)
				random_point(no_gaps ? 0 : $urandom_range(0, 19));
			// The sender holds off until every result is back.
			drain();
		end

		if (board.mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

>>> files.f
rtl/ppp_pkg.sv
rtl/ppp_div_step.sv
rtl/ppp_divider.sv
rtl/ppp_pixel.sv
rtl/perspective_point_projection.sv
tb/perspective_point_projection_test.sv
